// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SMM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMM_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMM_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/smm_pkg.sv =====
// types, codes and helpers of the substring match marker
package smm_pkg;

  localparam logic [7:0] MARK_CHAR = 8'd95;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;

  localparam int PAT_W = 64;
  localparam int PLEN_W = 4;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } smm_state_t;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_BYTE,
    PH_POST
  } smm_phase_t;

  // one text byte with the markers around it
  typedef struct packed {
    logic [7:0] ch;
    logic       mark_pre;
    logic       mark_post;
    logic       last;
  } smm_unit_t;

  function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] p, input logic [2:0] i);
    logic [PAT_W-1:0] sh;
    sh = p >> {i, 3'b000};
    return sh[7:0];
  endfunction

endpackage

// ===== rtl/smm_if.sv =====
// handshake interfaces of the input, result and configuration channels
interface smm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_string;
  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

interface smm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       inserted;
  logic       last_out;
  modport source (output valid, output char_out, output inserted, output last_out, input ready);
  modport sink (input valid, input char_out, input inserted, input last_out, output ready);
endinterface

interface smm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [smm_pkg::CFG_IDX_W-1:0]  idx;
  logic [smm_pkg::PAT_W-1:0]      wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ===== rtl/smm_cell.sv =====
// one window cell: holds a text byte and compares the byte shifting in
module smm_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  input  logic [7:0] pat,
  input  logic       used,
  output logic [7:0] dout,
  output logic       eq
);

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= din;
    end
  end

  assign dout = data_r;
  assign eq   = (din == pat) || !used;

endmodule

// ===== rtl/smm_core.sv =====
// window chain, match detection, coverage tracking and end of text drain
`include "assert_macros.svh"

module smm_core #(
  parameter int MAX_PATTERN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  smm_in_if.sink             in_ch,
  smm_cfg_if.sink            cfg_ch,
  input  logic               full,
  output logic               push,
  output smm_pkg::smm_unit_t unit
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [smm_pkg::PAT_W-1:0]  pat_r;
  logic [smm_pkg::PLEN_W-1:0] plen_r;

  smm_pkg::smm_state_t state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] cover_r, cover_nxt;
  logic              prev_r, prev_nxt;

  logic [FILL_W-1:0] len_act;
  logic [7:0] din  [MAX_PATTERN];
  logic [7:0] dout [MAX_PATTERN];
  logic [7:0] pbyte[MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;
  logic [MAX_PATTERN-1:0] used;
  logic accept;
  logic shift;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] fill_dec;
  logic [FILL_W-1:0] cov_sel;
  logic              covered;
  logic              emit;

  always_comb begin
    if (plen_r == '0) begin
      len_act = FILL_W'(1);
    end else if (plen_r > smm_pkg::PLEN_W'(MAX_PATTERN)) begin
      len_act = FILL_W'(MAX_PATTERN);
    end else begin
      len_act = plen_r[FILL_W-1:0];
    end
  end

  assign in_ch.ready = (state_r == smm_pkg::ST_RUN) && !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign shift       = accept;

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k == 0) begin : g_head
        assign din[k] = in_ch.char_in;
      end else begin : g_link
        assign din[k] = dout[k-1];
      end
      assign used[k]  = FILL_W'(k) < len_act;
      assign pbyte[k] = smm_pkg::pat_byte(pat_r, 3'(len_act - FILL_W'(1) - FILL_W'(k)));
      smm_cell u_cell (
        .clk  (clk),
        .shift(shift),
        .din  (din[k]),
        .pat  (pbyte[k]),
        .used (used[k]),
        .dout (dout[k]),
        .eq   (eq[k])
      );
    end
  endgenerate

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= smm_pkg::PLEN_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        smm_pkg::CFG_PATTERN: pat_r  <= cfg_ch.wdata;
        smm_pkg::CFG_LENGTH:  plen_r <= cfg_ch.wdata[smm_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smm_pkg::ST_RUN;
      fill_r  <= '0;
      cover_r <= '0;
      prev_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cover_r <= cover_nxt;
      prev_r  <= prev_nxt;
    end
  end

  assign fill_inc = fill_r + FILL_W'(1);
  assign fill_dec = fill_r - FILL_W'(1);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    cover_nxt = cover_r;
    prev_nxt  = prev_r;
    push      = 1'b0;
    unit      = '0;
    emit      = 1'b0;
    cov_sel   = cover_r;
    covered   = 1'b0;
    unique case (state_r)
      smm_pkg::ST_RUN: begin
        if (accept) begin
          emit = fill_inc >= len_act;
          if (emit) begin
            // match ends at the newest byte
            if ((&eq) && (cover_r < len_act)) begin
              cov_sel = len_act;
            end
            covered       = cov_sel != '0;
            push          = 1'b1;
            unit.ch       = din[fill_r[IDX_W-1:0]];
            unit.mark_pre = covered != prev_r;
            cover_nxt     = covered ? cov_sel - FILL_W'(1) : '0;
            prev_nxt      = covered;
            fill_nxt      = fill_r;
          end else begin
            fill_nxt = fill_inc;
          end
          if (in_ch.end_of_string) begin
            if (emit && (fill_r == '0)) begin
              unit.last      = 1'b1;
              unit.mark_post = covered;
              fill_nxt       = '0;
              cover_nxt      = '0;
              prev_nxt       = 1'b0;
            end else begin
              state_nxt = smm_pkg::ST_DRAIN;
            end
          end
        end
      end
      smm_pkg::ST_DRAIN: begin
        if (!full) begin
          covered       = cover_r != '0;
          push          = 1'b1;
          unit.ch       = dout[fill_dec[IDX_W-1:0]];
          unit.mark_pre = covered != prev_r;
          cover_nxt     = covered ? cover_r - FILL_W'(1) : '0;
          prev_nxt      = covered;
          fill_nxt      = fill_dec;
          if (fill_dec == '0) begin
            unit.last      = 1'b1;
            unit.mark_post = covered;
            cover_nxt      = '0;
            prev_nxt       = 1'b0;
            state_nxt      = smm_pkg::ST_RUN;
          end
        end
      end
      default: state_nxt = smm_pkg::ST_RUN;
    endcase
  end

  `SMM_NEVER(a_fill_bound, clk, rst_n, fill_r >= FILL_W'(MAX_PATTERN), "fill count overflow")
  `SMM_NEVER(a_drain_nonempty, clk, rst_n, (state_r == smm_pkg::ST_DRAIN) && (fill_r == '0), "drain with no held byte")
  `SMM_ASSERT(a_last_clears, clk, rst_n, (push && unit.last) |=> ((fill_r == '0) && (cover_r == '0) && !prev_r && (state_r == smm_pkg::ST_RUN)), "stream not cleared after last item")

endmodule

// ===== rtl/smm_emit.sv =====
// two entry unit queue and serializer onto the result channel
`include "assert_macros.svh"

module smm_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  smm_pkg::smm_unit_t unit,
  output logic               full,
  smm_out_if.source          out_ch
);

  smm_pkg::smm_unit_t mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  smm_pkg::smm_phase_t phase_r, phase_nxt;
  smm_pkg::smm_phase_t cur;
  smm_pkg::smm_unit_t  head;
  logic xfer;
  logic pop;

  assign head = mem_r[rd_r];
  assign full = cnt_r == 2'd2;
  assign xfer = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= unit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= smm_pkg::PH_PRE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    cur = ((phase_r == smm_pkg::PH_PRE) && !head.mark_pre) ? smm_pkg::PH_BYTE : phase_r;
    phase_nxt       = phase_r;
    pop             = 1'b0;
    out_ch.valid    = cnt_r != 2'd0;
    out_ch.char_out = smm_pkg::MARK_CHAR;
    out_ch.inserted = 1'b1;
    out_ch.last_out = 1'b0;
    unique case (cur)
      smm_pkg::PH_PRE: begin
        if (xfer) begin
          phase_nxt = smm_pkg::PH_BYTE;
        end
      end
      smm_pkg::PH_BYTE: begin
        out_ch.char_out = head.ch;
        out_ch.inserted = 1'b0;
        out_ch.last_out = head.last && !head.mark_post;
        if (xfer) begin
          if (head.mark_post) begin
            phase_nxt = smm_pkg::PH_POST;
          end else begin
            phase_nxt = smm_pkg::PH_PRE;
            pop       = 1'b1;
          end
        end
      end
      smm_pkg::PH_POST: begin
        out_ch.last_out = head.last;
        if (xfer) begin
          phase_nxt = smm_pkg::PH_PRE;
          pop       = 1'b1;
        end
      end
      default: phase_nxt = smm_pkg::PH_PRE;
    endcase
  end

  `SMM_NEVER(a_push_full, clk, rst_n, push && full && !pop, "unit pushed into full queue")
  `SMM_NEVER(a_cnt_range, clk, rst_n, cnt_r == 2'd3, "queue count out of range")
  `SMM_ASSERT(a_post_valid, clk, rst_n, (phase_r == smm_pkg::PH_POST) |-> ((cnt_r != 2'd0) && head.mark_post), "closing marker without a unit")

endmodule

// ===== rtl/substring_match_marker_top.sv =====
// window: a byte's results are queued when the item that completes its window is accepted,
// that is pattern length minus one items after the byte itself
// throughput: one item per cycle while no marker is due and the port is ready;
// each marker takes one more transfer of the result port
// end of text: input holds while held bytes drain, one result per ready cycle, up to ten results
// reset: synchronous rst_n clears the stream state, pattern zero, length one
module substring_match_marker_top #(
  parameter int MAX_PATTERN = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  smm_in_if.sink     in_ch,
  smm_out_if.source  out_ch,
  smm_cfg_if.sink    cfg_ch
);

  logic               push;
  logic               full;
  smm_pkg::smm_unit_t unit;

  smm_core #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg_ch(cfg_ch),
    .full  (full),
    .push  (push),
    .unit  (unit)
  );

  smm_emit u_emit (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .unit  (unit),
    .full  (full),
    .out_ch(out_ch)
  );

endmodule

// ===== tb/smm_highlight_checker.sv =====
`timescale 1ns / 1ps
// checker for the substring match marker: predicts the highlighted stream and compares results
module smm_highlight_checker (
  input  logic        clk,
  input  logic        rst_n,
  smm_in_if           in_ch,
  smm_out_if          out_ch,
  smm_cfg_if          cfg_ch,
  output int unsigned errors,
  output int unsigned pending
);

  localparam int MAX_PATTERN = 8;
  localparam int RESULT_CAP = MAX_PATTERN + 2;

  typedef struct packed {
    logic [7:0] ch;
    logic       ins;
    logic       last;
  } marked_byte_t;

  logic [smm_pkg::PAT_W-1:0]  pat_reg;
  logic [smm_pkg::PLEN_W-1:0] len_reg;
  logic [7:0]                 hist [MAX_PATTERN];
  int unsigned                held;
  int unsigned                cover_left;
  bit                         in_run;
  marked_byte_t               step_res[$];
  marked_byte_t               marked_q[$];
  int unsigned                err_cnt = 0;

  assign errors = err_cnt;

  task automatic clear_stream();
    for (int i = 0; i < MAX_PATTERN; i++) hist[i] = 8'h00;
    held = 0;
    cover_left = 0;
    in_run = 1'b0;
  endtask

  task automatic add_result(input logic [7:0] ch, input logic ins);
    marked_byte_t r;
    r.ch = ch;
    r.ins = ins;
    r.last = 1'b0;
    if (step_res.size() < RESULT_CAP) step_res = {step_res, r};
  endtask

  // a marker goes out whenever coverage flips between two text bytes
  task automatic emit_text(input logic [7:0] b);
    bit cov;
    cov = cover_left > 0;
    if (cov != in_run) add_result(smm_pkg::MARK_CHAR, 1'b1);
    add_result(b, 1'b0);
    if (cover_left > 0) cover_left--;
    in_run = cov;
  endtask

  task automatic predict_item(input logic [7:0] c, input logic eos);
    int unsigned  n;
    bit           hit;
    n = (len_reg == 0) ? 1 : (len_reg > MAX_PATTERN) ? MAX_PATTERN : len_reg;
    step_res.delete();
    for (int i = MAX_PATTERN - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = c;
    if (held < MAX_PATTERN) held++;
    if (held >= n) begin
      hit = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (hist[n-1-i] != pat_reg[8*i +: 8]) hit = 1'b0;
      end
      if (hit && cover_left < n) cover_left = n;
      held--;
      emit_text(hist[held]);
    end
    if (eos) begin
      while (held > 0) begin
        held--;
        emit_text(hist[held]);
      end
      if (in_run) add_result(smm_pkg::MARK_CHAR, 1'b1);
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
      clear_stream();
    end
    marked_q = {marked_q, step_res};
  endtask

  always @(posedge clk) begin : watch
    marked_byte_t got;
    marked_byte_t want;
    if (!rst_n) begin
      pat_reg = '0;
      len_reg = smm_pkg::PLEN_W'(1);
      clear_stream();
      marked_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.idx)
          smm_pkg::CFG_PATTERN: pat_reg = cfg_ch.wdata;
          smm_pkg::CFG_LENGTH: len_reg = cfg_ch.wdata[smm_pkg::PLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.char_in, in_ch.end_of_string);
      if (out_ch.valid && out_ch.ready) begin
        got.ch = out_ch.char_out;
        got.ins = out_ch.inserted;
        got.last = out_ch.last_out;
        if (marked_q.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: unexpected item ch=%h ins=%b last=%b", $realtime,
                     got.ch, got.ins, got.last);
          err_cnt++;
        end else begin
          want = marked_q.pop_front();
          if (got.ch !== want.ch || got.ins !== want.ins || got.last !== want.last) begin
            if (err_cnt < 10)
              $display("%0t: expected ch=%h ins=%b last=%b, got ch=%h ins=%b last=%b",
                       $realtime, want.ch, want.ins, want.last, got.ch, got.ins, got.last);
            err_cnt++;
          end
        end
      end
    end
    pending <= marked_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, text stimulus, handshake pacing and the verdict
module tb_top;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 370;

  logic        clk;
  logic        rst_n;
  int unsigned errors;
  int unsigned pending;
  bit          no_idle = 1'b0;
  int unsigned out_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  logic [63:0] cur_pat;
  int unsigned cur_len;

  smm_in_if  in_ch ();
  smm_out_if out_ch ();
  smm_cfg_if cfg_ch ();

  substring_match_marker_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  smm_highlight_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : out_pacing
    int unsigned n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      n = no_idle ? 0 : $urandom_range(0, 15);
      out_wait <= n;
      out_ch.ready <= (n == 0);
    end else if (out_wait != 0) begin
      out_wait <= out_wait - 1;
      out_ch.ready <= (out_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("substring_match_marker_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_char(input logic [7:0] c, input logic eos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_in <= c;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [smm_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic configure(input logic [63:0] pat, input logic [3:0] len);
    settle();
    write_reg(smm_pkg::CFG_PATTERN, pat);
    write_reg(smm_pkg::CFG_LENGTH, {60'd0, len});
    cfg_ch.valid <= 1'b0;
    cur_pat = pat;
    cur_len = (len == 0) ? 1 : (len > 8) ? 8 : len;
  endtask

  task automatic send_word(input logic [63:0] w, input int n, input logic eos);
    for (int i = 0; i < n; i++) push_char(w[8*i +: 8], eos && (i == n - 1));
  endtask

  initial begin : stim
    logic [7:0]  alpha [3];
    logic [7:0]  txt[$];
    logic [63:0] pat;
    logic [3:0]  len;
    int unsigned eff;
    int unsigned texts;
    int unsigned tlen;
    bit          open;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_in = 8'h00;
    in_ch.end_of_string = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = smm_pkg::CFG_PATTERN;
    cfg_ch.wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset pattern: single zero byte
    send_word(64'h4100, 2, 1'b1);
    // runs touching end to start
    configure(64'h6261, 4'd2);
    send_word(64'h62616261, 4, 1'b1);
    // overlapping occurrences
    configure(64'h6161, 4'd2);
    send_word(64'h616161, 3, 1'b1);
    // text shorter than the pattern
    configure('1, 4'd8);
    send_word('1, 3, 1'b1);
    // length zero acts as one
    configure(64'h0, 4'd0);
    send_word(64'h8000, 2, 1'b1);
    // oversized length, text left open
    configure(64'h0706050403020100, 4'd15);
    send_word(64'h0706050403020100, 8, 1'b0);
    // shrink mid-text, held bytes flush at end of string
    configure(64'h0706050403020100, 4'd1);
    send_word(64'h00, 1, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom);
      len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      eff = (len == 0) ? 1 : (len > 8) ? 8 : len;
      pat = {$urandom, $urandom};
      for (int i = 0; i < eff; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
      configure(pat, len);
      texts = $urandom_range(1, 4);
      for (int t = 0; t < texts; t++) begin
        tlen = $urandom_range(1, 16);
        txt.delete();
        while (txt.size() < tlen) begin
          if ($urandom_range(0, 2) == 0) begin
            for (int j = 0; j < cur_len; j++) txt = {txt, cur_pat[8*j +: 8]};
          end else if ($urandom_range(0, 9) == 0) begin
            txt = {txt, 8'($urandom)};
          end else begin
            txt = {txt, alpha[$urandom_range(0, 2)]};
          end
        end
        open = (t == texts - 1) && ($urandom_range(0, 3) == 0);
        foreach (txt[j]) push_char(txt[j], !open && (j == txt.size() - 1));
      end
    end
    push_char(8'($urandom), 1'b1);
    settle();

    if (errors == 0 && pending == 0) begin
      $display("substring_match_marker_top: match");
    end else begin
      $display("substring_match_marker_top: mismatch");
    end
    $finish;
  end

endmodule
